// ===== sv/bdgs_pkg.sv =====
// Package: shared types, constants and the sweep step table.
`default_nettype none
package bdgs_pkg;
    localparam int NUM_STEPS = 76;
    localparam int LEG_LEN   = 19;
    localparam logic [0:0] CFG_STEP_LENGTH      = 1'b0;
    localparam logic [0:0] CFG_CROSSFADE_LENGTH = 1'b1;

    // Delay in samples at 48 kHz and unsigned gain magnitude, indexed by angle.
    function automatic logic [9:0] leg_delay(input logic [4:0] idx);
        logic [9:0] d;
        begin
            case (idx)
                5'd0: d = 10'd0;    5'd1: d = 10'd2;    5'd2: d = 10'd4;
                5'd3: d = 10'd6;    5'd4: d = 10'd8;    5'd5: d = 10'd11;
                5'd6: d = 10'd13;   5'd7: d = 10'd15;   5'd8: d = 10'd17;
                5'd9: d = 10'd19;   5'd10: d = 10'd20;  5'd11: d = 10'd22;
                5'd12: d = 10'd24;  5'd13: d = 10'd26;  5'd14: d = 10'd27;
                5'd15: d = 10'd29;  5'd16: d = 10'd30;  5'd17: d = 10'd32;
                5'd18: d = 10'd33;
                default: d = 10'd0;
            endcase
            return d;
        end
    endfunction

    function automatic logic [16:0] leg_gain(input logic [4:0] idx);
        logic [16:0] g;
        begin
            case (idx)
                5'd0: g = 17'd66295;  5'd1: g = 17'd52827;  5'd2: g = 17'd42705;
                5'd3: g = 17'd35023;  5'd4: g = 17'd29139;  5'd5: g = 17'd24595;
                5'd6: g = 17'd21061;  5'd7: g = 17'd18296;  5'd8: g = 17'd16124;
                5'd9: g = 17'd14416;  5'd10: g = 17'd13076; 5'd11: g = 17'd12032;
                5'd12: g = 17'd11233; 5'd13: g = 17'd10638; 5'd14: g = 17'd10221;
                5'd15: g = 17'd9962;  5'd16: g = 17'd9851;  5'd17: g = 17'd9882;
                5'd18: g = 17'd10057;
                default: g = 17'd0;
            endcase
            return g;
        end
    endfunction

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_MULN  = 7'b0001000,
        S_MULO  = 7'b0010000,
        S_MIX   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;
endpackage
`default_nettype wire

// ===== sv/bdgs_if.sv =====
// Interfaces: sample channels and the configuration write channel.
`default_nettype none
interface bdgs_in_if #(parameter int SAMPLE_BITS = 24);
    logic valid;
    logic ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    modport source (output valid, left_in, right_in, input ready);
    modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface bdgs_out_if #(parameter int SAMPLE_BITS = 24);
    logic valid;
    logic ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [6:0] step_number;
    modport source (output valid, left_out, right_out, step_number, input ready);
    modport sink   (input valid, left_out, right_out, step_number, output ready);
endinterface

interface bdgs_cfg_if;
    logic valid;
    logic ready;
    logic [7:0] index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/bdgs_div.sv =====
// Restoring divider: quotient of a 41-bit numerator by a 24-bit divisor, one bit a cycle.
`default_nettype none
module bdgs_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [40:0] i_num,
    input  wire logic [23:0] i_den,
    output logic             o_done,
    output logic [16:0]      o_quot
);
    logic [40:0] r_num;
    logic [24:0] r_rem;
    logic [23:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [16:0] r_quot;
    logic [24:0] w_trial;
    logic [25:0] w_diff;

    assign w_trial = {r_rem[23:0], r_num[40]};
    assign w_diff  = {1'b0, w_trial} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                o_done <= 1'b0;
                r_busy <= 1'b1;
                r_cnt  <= 6'd41;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[39:0], 1'b0};
                if (!w_diff[25]) begin
                    r_rem  <= w_diff[24:0];
                    r_quot <= {r_quot[15:0], 1'b1};
                end else begin
                    r_rem  <= w_trial;
                    r_quot <= {r_quot[15:0], 1'b0};
                end
                r_cnt  <= r_cnt - 6'd1;
                o_done <= (r_cnt == 6'd1);
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end else begin
                o_done <= 1'b0;
            end
        end
    end
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== sv/binaural_delay_gain_sweep_top.sv =====
// Top level: ring delay line, sweep sequencer and shared multiplier.
`default_nettype none
// One stereo beat is taken at a time. For each beat the sequencer reads the ring in S_READ,
// waits in S_DIV for the crossfade weight from a one-bit-a-cycle divider, uses one shared
// 18x35 multiplier four times (gain products for both settings, then both crossfade mixes)
// in S_MULN, S_MULO and S_MIX, and loads the result register in S_OUT. A new beat may be
// taken while a result waits; the sequencer only holds in its last state if the previous
// result has still not been taken.
// The ring is a memory with a registered read port, read twice per beat. Ring
// entries never written read as zero through a fill count; no clearing pass is needed.
module binaural_delay_gain_sweep_top
    import bdgs_pkg::*;
#(
    parameter int RING_DEPTH  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bdgs_in_if.sink   s_in,
    bdgs_out_if.source m_out,
    bdgs_cfg_if.sink  s_cfg
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + 10;   // Q.8 side value width
    localparam int DW = PW + 1;
    localparam int MW = DW + 18;   // product width

    t_state r_state;
    logic [23:0] r_step_len, r_xf_len;
    logic signed [SB-1:0] r_ring [RING_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW:0]   r_fill;
    logic [6:0]  r_step;
    logic [23:0] r_sis;
    logic        r_load;
    logic [AW-1:0] r_nd, r_pd;
    logic signed [17:0] r_ng, r_pg;
    logic r_ns, r_ps;
    logic [23:0] r_fl, r_ft;
    logic signed [SB-1:0] r_mono, r_rd, r_dn, r_do;
    logic r_rsel;
    logic [1:0] r_rcnt;
    logic [16:0] r_w;
    logic signed [PW-1:0] r_nl, r_nr, r_ol, r_or;
    logic signed [SB-1:0] r_ml, r_mr;
    logic signed [SB-1:0] r_lo, r_ro;
    logic [6:0] r_onum;
    logic r_ovalid;
    logic r_half;

    logic signed [SB:0] w_sum;
    logic signed [SB-1:0] n_mono_w;
    assign w_sum   = {s_in.left_in[SB-1], s_in.left_in} + {s_in.right_in[SB-1], s_in.right_in};
    assign n_mono_w = w_sum[SB:1];

    // Ring write/read
    logic [AW-1:0] w_dsel;
    logic [AW-1:0] w_raddr;
    logic [AW:0] w_age;
    logic r_rzero;
    assign w_dsel  = r_rsel ? r_pd : r_nd;
    assign w_raddr = (r_wp >= w_dsel) ? r_wp - w_dsel : r_wp + AW'(RING_DEPTH) - w_dsel;
    assign w_age   = {1'b0, w_dsel};
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_in.valid && s_in.ready)
            r_ring[r_wp] <= n_mono_w;
        r_rd    <= r_ring[w_raddr];
        r_rzero <= (w_age >= r_fill);
    end

    // Step table lookup
    logic [6:0] w_k;
    logic [1:0] w_leg;
    logic [4:0] w_j, w_idx;
    logic [23:0] w_sl, w_ov;
    assign w_k   = (r_step < 7'(NUM_STEPS)) ? r_step : 7'd0;
    assign w_leg = (w_k >= 7'd57) ? 2'd3 : (w_k >= 7'd38) ? 2'd2 : (w_k >= 7'd19) ? 2'd1 : 2'd0;
    assign w_j   = 5'(w_k - 7'(w_leg) * 7'(LEG_LEN));
    assign w_idx = w_leg[0] ? 5'(LEG_LEN - 1) - w_j : w_j;
    assign w_sl  = (r_step_len == 24'd0) ? 24'd1 : r_step_len;
    always_comb begin
        w_ov = (r_xf_len == 24'd0) ? 24'd1 : r_xf_len;
        if (w_ov >= w_sl) w_ov = w_sl - 24'd1;
        if (w_ov == 24'd0) w_ov = 24'd1;
    end
    logic [9:0] w_tdel;
    assign w_tdel = leg_delay(w_idx);

    // Shared multiplier
    logic signed [17:0] w_ma;
    logic signed [DW-1:0] w_mb;
    logic signed [MW-1:0] w_prod;
    logic signed [MW-1:0] r_prod;
    logic [1:0] r_mcnt;
    logic signed [PW:0] w_diff_l, w_diff_r;
    always_comb begin
        w_diff_l = {r_nl[PW-1], r_nl} - {r_ol[PW-1], r_ol};
        w_diff_r = {r_nr[PW-1], r_nr} - {r_or[PW-1], r_or};
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MULN: begin w_ma = r_ng; w_mb = DW'(r_dn); end
            S_MULO: begin w_ma = r_pg; w_mb = DW'(r_do); end
            S_MIX:  begin
                w_ma = $signed({1'b0, r_w});
                w_mb = r_half ? DW'(w_diff_r) : DW'(w_diff_l);
            end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    logic signed [MW-1:0] w_q8;
    assign w_q8 = (r_prod + MW'(32'sd128)) >>> 8;
    logic signed [PW-1:0] w_mono8;
    assign w_mono8 = PW'(r_mono) <<< 8;

    logic signed [MW-1:0] w_mix;
    logic signed [MW-1:0] w_rnd;
    logic signed [SB-1:0] w_sat;
    localparam logic signed [MW-1:0] HI = MW'((64'sd1 <<< (SB-1)) - 1);
    localparam logic signed [MW-1:0] LO = -HI - MW'(1);
    always_comb begin
        w_mix = (MW'(r_half ? r_or : r_ol) <<< 16) + r_prod;
        w_rnd = (w_mix + MW'(32'sd8388608)) >>> 24;
        if (w_rnd > HI) w_sat = SB'(HI);
        else if (w_rnd < LO) w_sat = SB'(LO);
        else w_sat = SB'(w_rnd);
    end

    // Divider for the crossfade weight
    logic r_dstart, w_ddone;
    logic [16:0] w_dq;
    logic [23:0] r_m;
    bdgs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num({r_m, 17'd0} >> 1), .i_den(r_ft), .o_done(w_ddone), .o_quot(w_dq)
    );

    assign s_in.ready  = (r_state == S_IDLE);
    assign s_cfg.ready = 1'b1;
    assign m_out.valid = r_ovalid;
    assign m_out.left_out  = r_lo;
    assign m_out.right_out = r_ro;
    assign m_out.step_number = r_onum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step_len <= 24'd96000;
            r_xf_len <= 24'd4800;
            r_wp <= '0; r_fill <= '0; r_step <= '0; r_sis <= '0; r_load <= 1'b1;
            r_nd <= '0; r_pd <= '0; r_ng <= 18'sd65536; r_pg <= 18'sd65536;
            r_ns <= 1'b0; r_ps <= 1'b0; r_fl <= '0; r_ft <= '0;
            r_ovalid <= 1'b0; r_dstart <= 1'b0;
        end else begin
            if (s_cfg.valid) begin
                if (s_cfg.index == 8'(CFG_STEP_LENGTH)) r_step_len <= s_cfg.data;
                else if (s_cfg.index == 8'(CFG_CROSSFADE_LENGTH)) r_xf_len <= s_cfg.data;
            end
            // The result register loads in the last state, once the previous beat has gone.
            r_ovalid <= (r_state == S_OUT) ? 1'b1 : (r_ovalid && !m_out.ready);
            case (r_state)
                S_IDLE: if (s_in.valid && s_in.ready) begin
                    logic [23:0] v_fl, v_ft;
                    v_fl = r_fl; v_ft = r_ft;
                    r_mono <= n_mono_w;
                    if (r_load) begin
                        r_pd <= r_nd; r_pg <= r_ng; r_ps <= r_ns;
                        r_nd <= AW'(w_tdel);
                        r_ng <= w_leg[0] ? -$signed({1'b0, leg_gain(w_idx)})
                                         :  $signed({1'b0, leg_gain(w_idx)});
                        r_ns <= w_leg[1];
                        v_fl = w_ov; v_ft = w_ov;
                        r_load <= 1'b0;
                    end
                    r_ft <= v_ft;
                    if (v_fl != 24'd0) begin
                        r_m <= v_ft - v_fl + 24'd1;
                        r_fl <= v_fl - 24'd1;
                    end else begin
                        r_m <= v_ft;
                        r_fl <= v_fl;
                    end
                    if (r_fill != (AW+1)'(RING_DEPTH)) r_fill <= r_fill + 1'b1;
                    r_rsel <= 1'b0; r_rcnt <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    // Read-after-write: the current beat sits at the write pointer.
                    r_rcnt <= r_rcnt + 2'd1;
                    r_rsel <= 1'b1;
                    if (r_rcnt == 2'd1) r_dn <= r_rzero ? '0 : r_rd;
                    if (r_rcnt == 2'd2) begin
                        r_do <= r_rzero ? '0 : r_rd;
                        r_dstart <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dstart <= 1'b0;
                    if (w_ddone) begin
                        r_w <= (r_ft == 24'd0 || r_m >= r_ft) ? 17'd65536 : w_dq;
                        r_mcnt <= '0;
                        r_state <= S_MULN;
                    end
                end
                S_MULN: begin
                    if (r_mcnt == 2'd0) begin
                        r_prod <= w_prod;
                        r_mcnt <= r_mcnt + 2'd1;
                    end else begin
                        r_nl <= r_ns ? w_mono8 : PW'(w_q8);
                        r_nr <= r_ns ? PW'(w_q8) : w_mono8;
                        r_mcnt <= '0;
                        r_state <= S_MULO;
                    end
                end
                S_MULO: begin
                    if (r_mcnt == 2'd0) begin
                        r_prod <= w_prod;
                        r_mcnt <= r_mcnt + 2'd1;
                    end else begin
                        r_ol <= r_ps ? w_mono8 : PW'(w_q8);
                        r_or <= r_ps ? PW'(w_q8) : w_mono8;
                        r_mcnt <= '0; r_half <= 1'b0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt[0] == 1'b0) r_prod <= w_prod;
                    else begin
                        if (!r_half) r_ml <= w_sat;
                        else r_mr <= w_sat;
                        r_half <= 1'b1;
                        if (r_half) r_state <= S_OUT;
                    end
                end
                S_OUT: if (!r_ovalid || m_out.ready) begin
                    r_lo <= r_ml;
                    r_ro <= r_mr;
                    r_onum <= r_step;
                    r_wp <= (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                    if (r_sis + 24'd1 >= w_sl) begin
                        r_sis <= '0;
                        r_step <= (r_step >= 7'(NUM_STEPS - 1)) ? 7'd0 : r_step + 7'd1;
                        r_load <= 1'b1;
                    end else r_sis <= r_sis + 24'd1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_in.ready) else $error("ready while busy");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> r_ovalid) else $error("result missing");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < 7'(NUM_STEPS)) else $error("step out of range");
    a_fade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fl <= r_ft) else $error("fade count above total");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the binaural delay and gain sweep: random stereo beats checked against a predictor.
`default_nettype none
module tb;
    import bdgs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RING        = 64;
    localparam int  BEAT_CYCLES = 60;
    localparam int  STALL_LIMIT = 5000;
    localparam int  LONG_HOLD   = 600;
    localparam longint SMAX     = 64'sd8388607;
    localparam longint SMIN     = -64'sd8388608;
    localparam logic [7:0] IDX_STEP_LENGTH = {7'd0, CFG_STEP_LENGTH};
    localparam logic [7:0] IDX_XFADE       = {7'd0, CFG_CROSSFADE_LENGTH};
    localparam logic [7:0] IDX_UNUSED      = 8'd200;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } stereo_t;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [6:0]         step;
    } mix_t;

    logic i_clk;
    logic i_rst_n;

    bdgs_in_if  #(.SAMPLE_BITS(24)) in_if ();
    bdgs_out_if #(.SAMPLE_BITS(24)) out_if ();
    bdgs_cfg_if cfg_if ();

    binaural_delay_gain_sweep_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_if),
        .m_out   (out_if),
        .s_cfg   (cfg_if)
    );

    // Angle table of one leg: delay in nanoseconds and gain magnitude in Q1.16.
    longint angle_ns [19] = '{0, 44418, 88714, 132767, 176457, 219667, 262286, 304203,
        345317, 385530, 424753, 462901, 499902, 535689, 570207, 603407, 635254, 665720,
        694791};
    longint angle_gain [19] = '{66295, 52827, 42705, 35023, 29139, 24595, 21061, 18296,
        16124, 14416, 13076, 12032, 11233, 10638, 10221, 9962, 9851, 9882, 10057};

    // Shadow of the block's registers and sweep state.
    longint step_len_reg, xfade_reg;
    longint ring [RING];
    int     wr_ptr, step_idx, delay_new, delay_old;
    longint pos_in_step, gain_new, gain_old, fade_rem, fade_tot;
    bit     load_pend, side_new, side_old;

    stereo_t beat_q[$];
    mix_t    mix_expect_q[$];
    int      errors, beats_in, beats_out, quiet_cycles, cfg_writes;
    int      max_step_seen;
    bit      hold_done;

    function automatic longint div_floor(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint side_value(bit which, bit active, longint gain,
                                          longint delayed, longint mono);
        if (which == active) return div_floor(gain * delayed + 128, 256);
        return mono * 256;
    endfunction

    function automatic logic signed [23:0] crossfade(longint oldv, longint newv, longint w);
        longint r;
        r = div_floor(oldv * 65536 + w * (newv - oldv) + (64'sd1 <<< 23), 64'sd1 <<< 24);
        if (r > SMAX) r = SMAX;
        if (r < SMIN) r = SMIN;
        return r[23:0];
    endfunction

    function automatic void predict_mix(logic signed [23:0] l, logic signed [23:0] r);
        longint len, ov, mono, tap_new, tap_old, m, w;
        int     leg, j, a;
        mix_t   e;
        len = (step_len_reg == 0) ? 1 : step_len_reg;
        if (load_pend) begin
            ov = xfade_reg;
            if (ov < 1) ov = 1;
            if (ov >= len) ov = len - 1;
            if (ov < 1) ov = 1;
            leg = step_idx / 19;
            j   = step_idx % 19;
            a   = (leg % 2 == 1) ? 18 - j : j;
            delay_old = delay_new;
            gain_old  = gain_new;
            side_old  = side_new;
            delay_new = int'((angle_ns[a] * 48000 + 500000000) / 1000000000);
            gain_new  = (leg % 2 == 1) ? -angle_gain[a] : angle_gain[a];
            side_new  = (leg >= 2);
            fade_rem  = ov;
            fade_tot  = ov;
            load_pend = 0;
        end
        mono = div_floor(longint'(l) + longint'(r), 2);
        ring[wr_ptr] = mono;
        tap_new = ring[(wr_ptr + RING - (delay_new % RING)) % RING];
        tap_old = ring[(wr_ptr + RING - (delay_old % RING)) % RING];
        wr_ptr = (wr_ptr + 1) % RING;
        if (fade_rem > 0) begin
            m = fade_tot - fade_rem + 1;
            fade_rem--;
        end else begin
            m = fade_tot;
        end
        w = (fade_tot == 0 || m >= fade_tot) ? 65536 : (m * 65536) / fade_tot;
        e.left  = crossfade(side_value(0, side_old, gain_old, tap_old, mono),
                            side_value(0, side_new, gain_new, tap_new, mono), w);
        e.right = crossfade(side_value(1, side_old, gain_old, tap_old, mono),
                            side_value(1, side_new, gain_new, tap_new, mono), w);
        e.step  = step_idx[6:0];
        if (step_idx > max_step_seen) max_step_seen = step_idx;
        mix_expect_q.push_back(e);
        pos_in_step++;
        if (pos_in_step >= len) begin
            pos_in_step = 0;
            step_idx = (step_idx + 1 >= NUM_STEPS) ? 0 : step_idx + 1;
            load_pend = 1;
        end
    endfunction

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'(int'($urandom_range(0, 64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic void queue_beats(int n);
        stereo_t s;
        for (int k = 0; k < n; k++) begin
            s.left  = pick_sample();
            s.right = pick_sample();
            beat_q.push_back(s);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        stereo_t s;
        if (!i_rst_n) begin
            in_if.valid    <= 1'b0;
            in_if.left_in  <= '0;
            in_if.right_in <= '0;
            burst_left     <= 0;
            gap_left       <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_mix(in_if.left_in, in_if.right_in);
                beats_in++;
            end
            if (!(in_if.valid && !in_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left    <= gap_left - 1;
                    in_if.valid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    s = beat_q.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.left_in  <= s.left;
                    in_if.right_in <= s.right;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the stall pattern steps through four modes in turn; one long hold-off mid-run.
    int rx_cycle, hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_cycle     <= 0;
            hold_left    <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (!hold_done && beats_out >= 500) begin
                hold_done    = 1;
                hold_left    <= LONG_HOLD;
                out_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else begin
                case ((rx_cycle / 128) % 4)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= $urandom_range(0, 1);
                    2: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default: out_if.ready <= ((rx_cycle % 7) < 5);
                endcase
            end
        end
    end

    // Output checker.
    always @(posedge i_clk) begin
        mix_t e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            beats_out++;
            if (mix_expect_q.size() == 0) begin
                $error("output beat with nothing expected");
                errors++;
            end else begin
                e = mix_expect_q.pop_front();
                if (out_if.left_out !== e.left) begin
                    $error("left_out expected %0d got %0d", e.left, out_if.left_out);
                    errors++;
                end
                if (out_if.right_out !== e.right) begin
                    $error("right_out expected %0d got %0d", e.right, out_if.right_out);
                    errors++;
                end
                if (out_if.step_number !== e.step) begin
                    $error("step_number expected %0d got %0d", e.step, out_if.step_number);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted anywhere.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [23:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == IDX_STEP_LENGTH) step_len_reg = value;
        else if (idx == IDX_XFADE) xfade_reg = value;
        cfg_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (beat_q.size() > 0 || in_if.valid || mix_expect_q.size() > 0) @(posedge i_clk);
        repeat (BEAT_CYCLES * 2) @(posedge i_clk);
    endtask

    task automatic run_phase(longint step_len, longint xfade, int n);
        write_reg(IDX_STEP_LENGTH, step_len[23:0]);
        write_reg(IDX_XFADE, xfade[23:0]);
        queue_beats(n);
        drain();
    endtask

    initial begin
        stereo_t s;
        cfg_if.valid = 1'b0; cfg_if.index = '0;   cfg_if.data = '0;
        i_rst_n = 1'b0;
        step_len_reg = 96000; xfade_reg = 4800;
        foreach (ring[k]) ring[k] = 0;
        wr_ptr = 0; step_idx = 0; pos_in_step = 0; load_pend = 1;
        delay_new = 0; delay_old = 0; gain_new = 65536; gain_old = 65536;
        side_new = 0; side_old = 0; fade_rem = 0; fade_tot = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset settings: extremes and odd sums for the floor.
        s = '{24'sh7FFFFF, 24'sh7FFFFF};   beat_q.push_back(s);
        s = '{-24'sh800000, -24'sh800000}; beat_q.push_back(s);
        s = '{24'sh7FFFFF, -24'sh800000};  beat_q.push_back(s);
        s = '{-24'sh800000, 24'sh7FFFFF};  beat_q.push_back(s);
        s = '{24'sd0, 24'sd0};             beat_q.push_back(s);
        s = '{-24'sd1, 24'sd0};            beat_q.push_back(s);
        s = '{24'sd1, 24'sd0};             beat_q.push_back(s);
        s = '{-24'sd3, -24'sd2};           beat_q.push_back(s);
        s = '{24'sh555555, -24'sh2AAAAB};  beat_q.push_back(s);
        queue_beats(11);
        drain();

        // A zero step length behaves as one; a huge crossfade is clamped.
        run_phase(0, 0, 40);
        run_phase(1, 24'hFFFFFF, 60);
        run_phase(2, 1, 200);
        run_phase(7, 3, 300);
        run_phase(50, 40, 30);
        // Lowering the step length mid-step ends the step after the next beat.
        run_phase(5, 24'hFFFFFF, 300);
        // A write to an unused index must change nothing.
        write_reg(IDX_UNUSED, 24'h000003);
        run_phase(24'hFFFFFF, 4, 150);
        run_phase(13, 12, 220);

        $display("Run covered %0d beats in, %0d out, %0d register writes,", beats_in,
                 beats_out, cfg_writes);
        $display("sweep steps up to %0d, with one long output hold-off.", max_step_seen);
        if (errors == 0 && mix_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
